[rtl/atilt_pkg.sv]
package atilt_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned SQR_W       = 31;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned RAD_W       = 48;
  localparam int unsigned ROOT_W      = 24;
  localparam int unsigned REM_W       = 26;
  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned OPD_W       = 25;
  localparam int unsigned VEC_W       = 28;
  localparam int unsigned ANG_W       = 28;
  localparam int unsigned ANG_FRAC    = 24;
  localparam int unsigned TABLE_LEN   = 28;
  localparam int unsigned LANES       = 2;
  localparam int unsigned LANE_ROLL   = 0;
  localparam int unsigned LANE_PITCH  = 1;
  localparam int unsigned ROLL_W      = 9;
  localparam int unsigned PITCH_W     = 8;
  localparam int unsigned MUL_W       = 11;
  localparam int unsigned PROD_W      = ANG_W + MUL_W - 1;
  localparam int unsigned Q1_W        = PROD_W - 1 - ANG_FRAC;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned M_W         = Q1_W + RECIP_W;
  localparam int unsigned DQ_W        = M_W - RECIP_SHIFT;
  localparam int unsigned FIXED_LAT   = 7 + SQRT_STAGES;

  localparam logic signed [ANG_W-1:0] ANG_PI    = 28'sd52707179;
  localparam logic signed [MUL_W-1:0] DEG_MUL   = 11'sd573;
  localparam logic [RECIP_W-1:0]      RECIP10   = 16'd52429;
  localparam logic [DQ_W-1:0]         ROLL_LIM  = 10'd180;
  localparam logic [DQ_W-1:0]         PITCH_LIM = 10'd90;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
  } sample_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic                    zero;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] ang;
  } vec_t;

  typedef vec_t [LANES-1:0] lanes_t;

  function automatic logic signed [ANG_W-1:0] atan_angle(input int unsigned idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      0:       a = 28'sd13176795;
      1:       a = 28'sd7778716;
      2:       a = 28'sd4110060;
      3:       a = 28'sd2086331;
      4:       a = 28'sd1047214;
      5:       a = 28'sd524117;
      6:       a = 28'sd262123;
      7:       a = 28'sd131069;
      8:       a = 28'sd65536;
      9:       a = 28'sd32768;
      10:      a = 28'sd16384;
      11:      a = 28'sd8192;
      12:      a = 28'sd4096;
      13:      a = 28'sd2048;
      14:      a = 28'sd1024;
      15:      a = 28'sd512;
      16:      a = 28'sd256;
      17:      a = 28'sd128;
      18:      a = 28'sd64;
      19:      a = 28'sd32;
      20:      a = 28'sd16;
      21:      a = 28'sd8;
      22:      a = 28'sd4;
      23:      a = 28'sd2;
      24:      a = 28'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic vec_t prerot(input logic signed [OPD_W-1:0] yo,
                                  input logic signed [OPD_W-1:0] xo);
    vec_t                    v;
    logic signed [VEC_W-1:0] xe;
    logic signed [VEC_W-1:0] ye;
    xe = {{(VEC_W-OPD_W){xo[OPD_W-1]}}, xo};
    ye = {{(VEC_W-OPD_W){yo[OPD_W-1]}}, yo};
    v.zero = (xo == '0) && (yo == '0);
    if (xo[OPD_W-1]) begin
      v.ang = yo[OPD_W-1] ? -ANG_PI : ANG_PI;
      v.x   = -xe;
      v.y   = -ye;
    end else begin
      v.ang = '0;
      v.x   = xe;
      v.y   = ye;
    end
    return v;
  endfunction

endpackage

[rtl/atilt_sqrt_cell.sv]
module atilt_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  atilt_pkg::sample_t  sample_i,
  input  atilt_pkg::sqrt_t    sq_i,
  output logic                valid_o,
  output atilt_pkg::sample_t  sample_o,
  output atilt_pkg::sqrt_t    sq_o
);

  logic                          valid_q;
  atilt_pkg::sample_t            sample_q;
  atilt_pkg::sqrt_t              sq_q, sq_d;
  logic [atilt_pkg::REM_W+1:0]   rem_sh;
  logic [atilt_pkg::REM_W+1:0]   trial;
  logic [atilt_pkg::REM_W+1:0]   diff;

  always_comb begin
    rem_sh = {sq_i.rem, sq_i.rad[atilt_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, sq_i.root, 2'b01};
    diff   = rem_sh - trial;
    sq_d.rad = {sq_i.rad[atilt_pkg::RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_d.rem  = diff[atilt_pkg::REM_W-1:0];
      sq_d.root = {sq_i.root[atilt_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      sq_d.rem  = rem_sh[atilt_pkg::REM_W-1:0];
      sq_d.root = {sq_i.root[atilt_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_i;
    sq_q     <= sq_d;
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;
  assign sq_o     = sq_q;

endmodule

[rtl/atilt_cordic_cell.sv]
module atilt_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  atilt_pkg::lanes_t  lanes_i,
  output logic               valid_o,
  output atilt_pkg::lanes_t  lanes_o
);

  localparam logic signed [atilt_pkg::ANG_W-1:0] ANGLE = atilt_pkg::atan_angle(SHIFT);

  logic              valid_q;
  atilt_pkg::lanes_t lanes_q, lanes_d;

  always_comb begin
    logic signed [atilt_pkg::VEC_W-1:0] xc, yc, xs, ys;
    logic signed [atilt_pkg::ANG_W-1:0] ac;
    for (int l = 0; l < atilt_pkg::LANES; l++) begin
      xc = lanes_i[l].x;
      yc = lanes_i[l].y;
      ac = lanes_i[l].ang;
      xs = xc >>> SHIFT;
      ys = yc >>> SHIFT;
      lanes_d[l].zero = lanes_i[l].zero;
      if (!yc[atilt_pkg::VEC_W-1]) begin
        lanes_d[l].x   = xc + ys;
        lanes_d[l].y   = yc - xs;
        lanes_d[l].ang = ac + ANGLE;
      end else begin
        lanes_d[l].x   = xc - ys;
        lanes_d[l].y   = yc + xs;
        lanes_d[l].ang = ac - ANGLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

[rtl/atilt_deg.sv]
module atilt_deg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  atilt_pkg::lanes_t                    lanes_i,
  output logic                                 done_o,
  output logic signed [atilt_pkg::ROLL_W-1:0]  roll_deg_o,
  output logic signed [atilt_pkg::PITCH_W-1:0] pitch_deg_o
);

  localparam int unsigned L = atilt_pkg::LANES;

  logic [3:0] v_q;

  logic signed [atilt_pkg::PROD_W-1:0] p_q  [L];
  logic signed [atilt_pkg::PROD_W-1:0] p_d  [L];
  logic [atilt_pkg::Q1_W-1:0]          q1_q [L];
  logic [atilt_pkg::Q1_W-1:0]          q1_d [L];
  logic [atilt_pkg::M_W-1:0]           m_q  [L];
  logic [atilt_pkg::M_W-1:0]           m_d  [L];
  logic signed [atilt_pkg::ROLL_W-1:0] r_q  [L];
  logic signed [atilt_pkg::ROLL_W-1:0] r_d  [L];
  logic                                n2_q [L];
  logic                                n3_q [L];
  logic                                n2_d [L];

  always_comb begin
    logic signed [atilt_pkg::ANG_W-1:0]  ac;
    logic signed [atilt_pkg::PROD_W-1:0] ae, ce, av;
    logic [atilt_pkg::DQ_W-1:0]          dq, lim, mag;
    logic [atilt_pkg::ROLL_W-1:0]        mag9;
    for (int l = 0; l < L; l++) begin
      ac = lanes_i[l].ang;
      ae = $signed({{(atilt_pkg::PROD_W-atilt_pkg::ANG_W){ac[atilt_pkg::ANG_W-1]}}, ac});
      ce = $signed({{(atilt_pkg::PROD_W-atilt_pkg::MUL_W){1'b0}}, atilt_pkg::DEG_MUL});
      p_d[l] = lanes_i[l].zero ? '0 : ae * ce;

      n2_d[l] = p_q[l][atilt_pkg::PROD_W-1];
      av      = n2_d[l] ? -p_q[l] : p_q[l];
      q1_d[l] = av[atilt_pkg::PROD_W-2:atilt_pkg::ANG_FRAC];

      m_d[l] = {{atilt_pkg::RECIP_W{1'b0}}, q1_q[l]} *
               {{atilt_pkg::Q1_W{1'b0}}, atilt_pkg::RECIP10};

      lim  = (l == atilt_pkg::LANE_ROLL) ? atilt_pkg::ROLL_LIM : atilt_pkg::PITCH_LIM;
      dq   = m_q[l][atilt_pkg::M_W-1:atilt_pkg::RECIP_SHIFT];
      mag  = (dq > lim) ? lim : dq;
      mag9 = mag[atilt_pkg::ROLL_W-1:0];
      r_d[l] = n3_q[l] ? -$signed(mag9) : $signed(mag9);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < L; l++) begin
      p_q[l]  <= p_d[l];
      q1_q[l] <= q1_d[l];
      n2_q[l] <= n2_d[l];
      m_q[l]  <= m_d[l];
      n3_q[l] <= n2_q[l];
      r_q[l]  <= r_d[l];
    end
  end

  assign done_o      = v_q[3];
  assign roll_deg_o  = r_q[atilt_pkg::LANE_ROLL];
  assign pitch_deg_o = r_q[atilt_pkg::LANE_PITCH][atilt_pkg::PITCH_W-1:0];

endmodule

[rtl/accel_tilt_angles_unit.sv]
// Roll and pitch in whole degrees from one X/Y/Z accelerometer sample. The unit takes a
// sample in every clock cycle: busy_o stays low, so a word is taken at each edge where
// start_i is high. Each result word shows on done_o, roll_deg_o and pitch_deg_o for exactly
// one cycle, once its sample has passed the squaring and sum stages, 24 square-root cells,
// one pre-rotation stage, the row of CORDIC cells and four degree-scaling stages. The
// receiver cannot stall the unit and must take each word in the cycle it is shown.
// CORDIC_STAGES above 28 builds 28 cells.
module accel_tilt_angles_unit #(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_x_i,
  input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_y_i,
  input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_z_i,
  output logic                                 done_o,
  output logic signed [atilt_pkg::ROLL_W-1:0]  roll_deg_o,
  output logic signed [atilt_pkg::PITCH_W-1:0] pitch_deg_o
);

  localparam int unsigned CN = (CORDIC_STAGES > atilt_pkg::TABLE_LEN) ?
                               atilt_pkg::TABLE_LEN : CORDIC_STAGES;
  localparam int unsigned SN = atilt_pkg::SQRT_STAGES;
  localparam int unsigned OW = atilt_pkg::OPD_W;

  logic                        v1_q, v2_q, vp_q;
  atilt_pkg::sample_t          s1_q, s2_q;
  logic [atilt_pkg::SQR_W-1:0] xx_q, zz_q;
  logic [atilt_pkg::SUM_W-1:0] sum;
  logic signed [2*atilt_pkg::SAMPLE_W-1:0] xx_d, zz_d;
  atilt_pkg::sqrt_t            sq2_q;

  logic               sv   [SN+1];
  atilt_pkg::sample_t ss   [SN+1];
  atilt_pkg::sqrt_t   sq   [SN+1];

  logic               cv   [CN+1];
  atilt_pkg::lanes_t  cl   [CN+1];

  atilt_pkg::sample_t se;
  logic signed [atilt_pkg::SAMPLE_W:0] nx;
  logic signed [OW-1:0] roll_y, roll_x, pitch_y, pitch_x;
  atilt_pkg::lanes_t  prep_d, prep_q;

  assign busy_o = 1'b0;

  assign xx_d = accel_x_i * accel_x_i;
  assign zz_d = accel_z_i * accel_z_i;
  assign sum  = {1'b0, xx_q} + {1'b0, zz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vp_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      vp_q <= sv[SN];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q.x    <= accel_x_i;
    s1_q.y    <= accel_y_i;
    s1_q.z    <= accel_z_i;
    xx_q      <= xx_d[atilt_pkg::SQR_W-1:0];
    zz_q      <= zz_d[atilt_pkg::SQR_W-1:0];
    s2_q      <= s1_q;
    sq2_q.rad <= {sum, {(atilt_pkg::RAD_W-atilt_pkg::SUM_W){1'b0}}};
    sq2_q.rem <= '0;
    sq2_q.root <= '0;
    prep_q    <= prep_d;
  end

  assign sv[0] = v2_q;
  assign ss[0] = s2_q;
  assign sq[0] = sq2_q;

  for (genvar i = 0; i < SN; i++) begin : g_sqrt
    atilt_sqrt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (sv[i]),
      .sample_i (ss[i]),
      .sq_i     (sq[i]),
      .valid_o  (sv[i+1]),
      .sample_o (ss[i+1]),
      .sq_o     (sq[i+1])
    );
  end

  assign se      = ss[SN];
  assign nx      = -$signed({se.x[atilt_pkg::SAMPLE_W-1], se.x});
  assign roll_y  = $signed({nx, 8'h00});
  assign roll_x  = $signed({se.z[atilt_pkg::SAMPLE_W-1], se.z, 8'h00});
  assign pitch_y = $signed({se.y[atilt_pkg::SAMPLE_W-1], se.y, 8'h00});
  assign pitch_x = $signed({1'b0, sq[SN].root});

  always_comb begin
    prep_d[atilt_pkg::LANE_ROLL]  = atilt_pkg::prerot(roll_y, roll_x);
    prep_d[atilt_pkg::LANE_PITCH] = atilt_pkg::prerot(pitch_y, pitch_x);
  end

  assign cv[0] = vp_q;
  assign cl[0] = prep_q;

  for (genvar i = 0; i < CN; i++) begin : g_cordic
    atilt_cordic_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .lanes_i (cl[i]),
      .valid_o (cv[i+1]),
      .lanes_o (cl[i+1])
    );
  end

  atilt_deg u_deg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cv[CN]),
    .lanes_i     (cl[CN]),
    .done_o      (done_o),
    .roll_deg_o  (roll_deg_o),
    .pitch_deg_o (pitch_deg_o)
  );

endmodule

[rtl/atilt_chk.sv]
module atilt_chk #(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic signed [atilt_pkg::SAMPLE_W-1:0] accel_x_i,
  input logic signed [atilt_pkg::SAMPLE_W-1:0] accel_y_i,
  input logic signed [atilt_pkg::SAMPLE_W-1:0] accel_z_i,
  input logic                                 done_o,
  input logic signed [atilt_pkg::ROLL_W-1:0]  roll_deg_o,
  input logic signed [atilt_pkg::PITCH_W-1:0] pitch_deg_o
);

  localparam int unsigned CN  = (CORDIC_STAGES > atilt_pkg::TABLE_LEN) ?
                                atilt_pkg::TABLE_LEN : CORDIC_STAGES;
  localparam int unsigned LAT = atilt_pkg::FIXED_LAT + CN;

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised on a fully pipelined unit");

  a_word_from_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result word without a sample taken at the pipeline depth");

  a_roll_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_deg_o <= 9'sd180) && (roll_deg_o >= -9'sd180))
    else $error("roll out of range");

  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pitch_deg_o <= 8'sd90) && (pitch_deg_o >= -8'sd90))
    else $error("pitch out of range");

  a_level_roll : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(accel_x_i == '0 && accel_z_i == '0, LAT) |-> roll_deg_o == '0)
    else $error("roll not zero for zero X and Z");

endmodule

bind accel_tilt_angles_unit atilt_chk #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_atilt_chk (.*);
